### hdl/gpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpid_pkg - shared types and constants of the gated pid controller
// widths, register indexes, codes and the structs passed between modules
// ----------------------------------------------------------------------------
package gpid_pkg;

    // data path widths
    localparam int DATA_WIDTH     = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int GAIN_W         = 24;
    localparam int MODE_W         = 2;
    localparam int LIMIT_W        = 15;
    localparam int TICK_W         = 16;
    localparam int SUM_W          = 32;
    localparam int ERR_W          = DATA_WIDTH + 1;
    localparam int DIFF_W         = DATA_WIDTH + 2;
    localparam int SUMX_W         = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;

    // product and accumulator widths, gains are widened by a zero sign bit
    localparam int P_W      = GAIN_W + 1 + ERR_W;
    localparam int D_W      = GAIN_W + 1 + DIFF_W;
    localparam int I_W      = GAIN_W + 1 + SUM_W;
    localparam int OPND_W   = (DIFF_W > SUM_W) ? DIFF_W : SUM_W;
    localparam int ACC_W    = GAIN_W + 1 + OPND_W + 2;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((3 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = GAIN_W;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_KP     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KI     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KD     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD = 3'd5;

    // register reset values
    localparam logic [GAIN_W-1:0]  KP_RESET     = 24'd1024;
    localparam logic [GAIN_W-1:0]  KI_RESET     = 24'd204800;
    localparam logic [GAIN_W-1:0]  KD_RESET     = 24'd1024;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 15'd1500;
    localparam logic [TICK_W-1:0]  PERIOD_RESET = 16'd20;

    // controller modes, the reserved code behaves as full pid
    localparam logic [MODE_W-1:0] MODE_P        = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PD       = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PID      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    // item kinds
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // error sum bounds
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [TICK_W-1:0]       TICK_MAX = {TICK_W{1'b1}};

    // strobes and operands into the state stage
    typedef struct packed {
        logic                         tick;
        logic                         sample;
        logic signed [DATA_WIDTH-1:0] measured;
        logic signed [DATA_WIDTH-1:0] setpoint;
    } step_t;

    // values out of the state stage
    typedef struct packed {
        logic                     compute;
        logic signed [ERR_W-1:0]  err;
        logic signed [DIFF_W-1:0] diff;
        logic signed [SUM_W-1:0]  sum;
    } calc_t;

endpackage

### hdl/gpid_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpid_state - tick counter, error sum and previous error
// gates samples by the period and forms error, difference and new sum
// ----------------------------------------------------------------------------
module gpid_state (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [gpid_pkg::TICK_W-1:0] sample_period,
    input  gpid_pkg::step_t             step,
    output gpid_pkg::calc_t             calc
);
    import gpid_pkg::*;

    logic [TICK_W-1:0]       tick_count_reg;
    logic [TICK_W-1:0]       tick_count_next;
    logic signed [SUM_W-1:0] error_sum_reg;
    logic signed [SUM_W-1:0] error_sum_next;
    logic signed [ERR_W-1:0] prev_err_reg;
    logic signed [ERR_W-1:0] prev_err_next;
    logic signed [SUMX_W-1:0] sum_wide;
    logic                    update;

    always_comb
    begin
        calc.compute = (tick_count_reg >= sample_period);
        calc.err     = ERR_W'(step.setpoint) - ERR_W'(step.measured);
        calc.diff    = DIFF_W'(calc.err) - DIFF_W'(prev_err_reg);
        sum_wide     = SUMX_W'(error_sum_reg) + SUMX_W'(calc.err);
        // saturate to the signed 32 bit range
        if (sum_wide > SUMX_W'(SUM_MAX))
        begin
            calc.sum = SUM_MAX;
        end
        else if (sum_wide < SUMX_W'(SUM_MIN))
        begin
            calc.sum = SUM_MIN;
        end
        else
        begin
            calc.sum = SUM_W'(sum_wide);
        end
    end

    assign update = step.sample && calc.compute;

    always_comb
    begin
        tick_count_next = tick_count_reg;
        error_sum_next  = error_sum_reg;
        prev_err_next   = prev_err_reg;
        if (step.tick && (tick_count_reg != TICK_MAX))
        begin
            tick_count_next = tick_count_reg + TICK_W'(1);
        end
        if (update)
        begin
            tick_count_next = '0;
            error_sum_next  = calc.sum;
            prev_err_next   = calc.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            error_sum_reg  <= '0;
            prev_err_reg   <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            error_sum_reg  <= error_sum_next;
            prev_err_reg   <= prev_err_next;
        end
    end

    // a computed sample restarts the period
    a_compute_clears: assert property (@(posedge clk) disable iff (!rst_n)
        update |=> (tick_count_reg == '0))
        else $error("tick counter not cleared after a computed sample");

    // the counter holds at its top value
    a_tick_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (step.tick && !step.sample && (tick_count_reg == TICK_MAX))
            |=> (tick_count_reg == TICK_MAX))
        else $error("tick counter wrapped");

endmodule

### hdl/gated_pid_with_modes_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_pid_with_modes_top - gated positional pid controller
// p, pd or pid terms with fixed point gains, clamped, sample rate gated
// ----------------------------------------------------------------------------
//  channel  | direction | signals                              | item
//  ---------+-----------+--------------------------------------+--------------------------
//  s_       | in        | s_tvalid s_tready s_tdata s_tuser    | tick or sample request
//  m_       | out       | m_tvalid m_tready m_tdata m_tuser    | drive value, computed flag
//  cfg_     | in        | cfg_we cfg_addr cfg_data             | register write
//
//  one item accepted per cycle while s_tready is high; a sample item passes from the
//  input register through the state, multiply and sum/clamp stages into the output
//  register
//  tick items finish in the state stage in the cycle after acceptance, no result
//  reset clears the tick counter, error sum, previous error and all valid
//  flags, and loads the register defaults
//  a stalled output holds its item; the stages behind it keep filling and
//  s_tready drops only when all four stages hold an item
// ----------------------------------------------------------------------------
module gated_pid_with_modes_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // measured, setpoint, fallback (from bit 0 up)
    input  logic [gpid_pkg::IN_TDATA_W-1:0]  s_tdata,
    // op: 0 tick, 1 sample request
    input  logic [0:0]                       s_tuser,
    // master side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // drive
    output logic [gpid_pkg::OUT_TDATA_W-1:0] m_tdata,
    // computed
    output logic [0:0]                       m_tuser,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [gpid_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [gpid_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import gpid_pkg::*;

    localparam int DW = DATA_WIDTH;

    // configuration registers
    logic [GAIN_W-1:0]  kp_reg;
    logic [GAIN_W-1:0]  ki_reg;
    logic [GAIN_W-1:0]  kd_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [TICK_W-1:0]  period_reg;

    // input stage
    logic                 s0_valid_reg;
    logic                 s0_op_reg;
    logic signed [DW-1:0] s0_meas_reg;
    logic signed [DW-1:0] s0_setp_reg;
    logic signed [DW-1:0] s0_fb_reg;
    logic                 s0_fire;
    logic                 s0_sample_fire;

    // state stage outputs
    logic                     s1_valid_reg;
    logic                     s1_comp_reg;
    logic signed [DW-1:0]     s1_fb_reg;
    logic signed [ERR_W-1:0]  s1_err_reg;
    logic signed [DIFF_W-1:0] s1_diff_reg;
    logic signed [SUM_W-1:0]  s1_sum_reg;
    logic                     s1_ready;

    // multiply stage outputs
    logic                  s2_valid_reg;
    logic                  s2_comp_reg;
    logic signed [DW-1:0]  s2_fb_reg;
    logic signed [P_W-1:0] s2_p_reg;
    logic signed [D_W-1:0] s2_d_reg;
    logic signed [I_W-1:0] s2_i_reg;
    logic                  s2_ready;
    logic signed [P_W-1:0] p_next;
    logic signed [D_W-1:0] d_next;
    logic signed [I_W-1:0] i_next;
    logic                  use_d;
    logic                  use_i;

    // sum and clamp, result register
    logic                    out_valid_reg;
    logic signed [DW-1:0]    drive_reg;
    logic signed [DW-1:0]    drive_next;
    logic                    computed_reg;
    logic                    s3_ready;
    logic signed [ACC_W-1:0] acc;
    logic                    acc_neg;
    logic [ACC_W-1:0]        acc_mag;
    logic [ACC_W-1:0]        acc_shift;
    logic [LIMIT_W-1:0]      mag_clamp;
    logic signed [LIMIT_W:0] res;

    step_t step;
    calc_t calc;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= KP_RESET;
            ki_reg     <= KI_RESET;
            kd_reg     <= KD_RESET;
            mode_reg   <= MODE_PD;
            limit_reg  <= LIMIT_RESET;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_KP:     kp_reg     <= cfg_data[GAIN_W-1:0];
                REG_KI:     ki_reg     <= cfg_data[GAIN_W-1:0];
                REG_KD:     kd_reg     <= cfg_data[GAIN_W-1:0];
                REG_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_PERIOD: period_reg <= cfg_data[TICK_W-1:0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake chain: a stage takes an item when it is empty or moving on
    // ------------------------------------------------------------------
    assign s3_ready       = !out_valid_reg || m_tready;
    assign s2_ready       = !s2_valid_reg || s3_ready;
    assign s1_ready       = !s1_valid_reg || s2_ready;
    // ticks retire in the state stage and never wait on downstream
    assign s0_fire        = s0_valid_reg && ((s0_op_reg == OP_TICK) || s1_ready);
    assign s0_sample_fire = s0_fire && (s0_op_reg == OP_SAMPLE);
    assign s_tready       = !s0_valid_reg || s0_fire;

    // ------------------------------------------------------------------
    // input stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s0_op_reg   <= s_tuser[0];
            s0_meas_reg <= s_tdata[DW-1:0];
            s0_setp_reg <= s_tdata[2*DW-1:DW];
            s0_fb_reg   <= s_tdata[3*DW-1:2*DW];
        end
    end

    // ------------------------------------------------------------------
    // state stage: gating, error, difference, saturating sum
    // ------------------------------------------------------------------
    always_comb
    begin
        step.tick     = s0_fire && (s0_op_reg == OP_TICK);
        step.sample   = s0_sample_fire;
        step.measured = s0_meas_reg;
        step.setpoint = s0_setp_reg;
    end

    gpid_state u_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_period (period_reg),
        .step          (step),
        .calc          (calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= s0_sample_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_sample_fire)
        begin
            s1_comp_reg <= calc.compute;
            s1_fb_reg   <= s0_fb_reg;
            s1_err_reg  <= calc.err;
            s1_diff_reg <= calc.diff;
            s1_sum_reg  <= calc.sum;
        end
    end

    // ------------------------------------------------------------------
    // multiply stage: one product per term, unused terms forced to zero
    // ------------------------------------------------------------------
    assign use_d = (mode_reg != MODE_P);
    assign use_i = (mode_reg == MODE_PID) || (mode_reg == MODE_RESERVED);

    always_comb
    begin
        p_next = P_W'($signed({1'b0, kp_reg})) * P_W'(s1_err_reg);
        d_next = '0;
        i_next = '0;
        if (use_d)
        begin
            d_next = D_W'($signed({1'b0, kd_reg})) * D_W'(s1_diff_reg);
        end
        if (use_i)
        begin
            i_next = I_W'($signed({1'b0, ki_reg})) * I_W'(s1_sum_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_comp_reg <= s1_comp_reg;
            s2_fb_reg   <= s1_fb_reg;
            s2_p_reg    <= p_next;
            s2_d_reg    <= d_next;
            s2_i_reg    <= i_next;
        end
    end

    // ------------------------------------------------------------------
    // sum, scale toward zero, clamp to the limit
    // ------------------------------------------------------------------
    always_comb
    begin
        acc       = ACC_W'(s2_p_reg) + ACC_W'(s2_d_reg) + ACC_W'(s2_i_reg);
        acc_neg   = acc[ACC_W-1];
        acc_mag   = acc_neg ? ACC_W'(-acc) : ACC_W'(acc);
        acc_shift = acc_mag >> GAIN_FRAC_BITS;
        if (acc_shift > ACC_W'(limit_reg))
        begin
            mag_clamp = limit_reg;
        end
        else
        begin
            mag_clamp = acc_shift[LIMIT_W-1:0];
        end
        res        = acc_neg ? -$signed({1'b0, mag_clamp}) : $signed({1'b0, mag_clamp});
        drive_next = s2_comp_reg ? DW'(res) : s2_fb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ready)
        begin
            drive_reg    <= drive_next;
            computed_reg <= s2_comp_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = OUT_TDATA_W'($unsigned(drive_reg));
    assign m_tuser[0] = computed_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // a computed drive never exceeds the limit
    a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && computed_reg) |->
            ((32'(drive_reg) <= $signed(32'(limit_reg)))
             && (32'(drive_reg) >= -$signed(32'(limit_reg)))))
        else $error("computed drive outside the limit");

    // a sample leaving the input stage always lands in the state stage
    a_sample_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s0_sample_fire |=> s1_valid_reg)
        else $error("sample item lost after the state stage");

    // input is refused only when every stage holds an item
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s0_valid_reg && s1_valid_reg && s2_valid_reg && out_valid_reg))
        else $error("input refused with room in the pipeline");

endmodule

### bench/tb_gated_pid_with_modes_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gated_pid_with_modes_top - self-checking bench for the gated pid block
// drives tick and sample items through the input stream and writes the
// registers between phases. A behavioral controller model predicts each
// drive value and computed flag, and a checker compares every output item
// in order. Covers register defaults, gain and data extremes, all modes,
// truncation, the period gate, large error sum swings, and a
// long output stall. A long random part runs mostly with gaps on both sides.
// ----------------------------------------------------------------------------
module tb_gated_pid_with_modes_top;

    import gpid_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRINT_CAP     = 30;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] drive;
        logic                         computed;
    } drive_result_t;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    // measured, setpoint, fallback (from bit 0 up)
    logic [IN_TDATA_W-1:0]    s_tdata  = '0;
    // op
    logic [0:0]               s_tuser  = OP_TICK;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    // drive
    logic [OUT_TDATA_W-1:0]   m_tdata;
    // computed
    logic [0:0]               m_tuser;
    logic                     cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0]    cfg_addr = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    gated_pid_with_modes_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // register copies, as last written
    logic [GAIN_W-1:0]  kp_reg     = KP_RESET;
    logic [GAIN_W-1:0]  ki_reg     = KI_RESET;
    logic [GAIN_W-1:0]  kd_reg     = KD_RESET;
    logic [MODE_W-1:0]  mode_reg   = MODE_PD;
    logic [LIMIT_W-1:0] limit_reg  = LIMIT_RESET;
    logic [TICK_W-1:0]  period_reg = PERIOD_RESET;

    // controller state copies
    logic [TICK_W-1:0]  tick_count = '0;
    longint             err_sum    = 0;
    longint             prev_err   = 0;

    drive_result_t      pending_drives [$];

    int  mismatches     = 0;
    int  items_in       = 0;
    int  results_seen   = 0;
    int  computed_seen  = 0;
    int  in_stall_count = 0;
    int  cycle_count    = 0;
    bit  tx_idle_on     = 1'b0;
    bit  rx_idle_on     = 1'b0;
    int  hold_len       = 0;
    int  hold_seq       = 0;

    // receiver-owned
    int  hold_seen      = 0;
    int  rx_hold_left   = 0;
    int  rx_stall_left  = 0;

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // mostly no gap, some short, a few long
    function automatic int pick_gap(input bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one controller step on an accepted item
    function automatic void predict_drive(input logic op,
                                          input logic signed [DATA_WIDTH-1:0] meas,
                                          input logic signed [DATA_WIDTH-1:0] setp,
                                          input logic signed [DATA_WIDTH-1:0] fb);
        longint        err;
        longint        diff;
        longint        acc;
        longint        mag;
        longint        res;
        drive_result_t r;
        if (op == OP_TICK)
        begin
            if (tick_count != TICK_MAX)
                tick_count++;
            return;
        end
        if (tick_count < period_reg)
        begin
            r.drive    = fb;
            r.computed = 1'b0;
            pending_drives.push_back(r);
            return;
        end
        tick_count = '0;
        err = longint'(setp) - longint'(meas);
        err_sum += err;
        if (err_sum > longint'(SUM_MAX))
            err_sum = longint'(SUM_MAX);
        if (err_sum < longint'(SUM_MIN))
            err_sum = longint'(SUM_MIN);
        diff     = err - prev_err;
        prev_err = err;
        acc = longint'(kp_reg) * err;
        if (mode_reg != MODE_P)
            acc += longint'(kd_reg) * diff;
        // reserved code acts as full pid
        if (mode_reg == MODE_PID || mode_reg == MODE_RESERVED)
            acc += longint'(ki_reg) * err_sum;
        // magnitude scaled down truncates toward zero, then clamp
        mag = (acc < 0) ? -acc : acc;
        mag = mag >> GAIN_FRAC_BITS;
        if (mag > longint'(limit_reg))
            mag = longint'(limit_reg);
        res = (acc < 0) ? -mag : mag;
        r.drive    = res[DATA_WIDTH-1:0];
        r.computed = 1'b1;
        pending_drives.push_back(r);
    endfunction

    // offer one item, wait for the handshake, then predict
    task automatic push_item(input logic op,
                             input logic signed [DATA_WIDTH-1:0] meas,
                             input logic signed [DATA_WIDTH-1:0] setp,
                             input logic signed [DATA_WIDTH-1:0] fb);
        int gap;
        gap = pick_gap(tx_idle_on);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {fb, setp, meas};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
        begin
            in_stall_count++;
            @(posedge clk);
        end
        predict_drive(op, meas, setp, fb);
        items_in++;
    endtask

    // stop offering and wait for every expected item, then let ticks finish
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_drives.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_drives.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected items never arrived",
                                      pending_drives.size()));
            pending_drives.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all six registers while the block is idle
    task automatic set_config(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [MODE_W-1:0] md,
                              input logic [LIMIT_W-1:0] lim,
                              input logic [TICK_W-1:0] per);
        logic [CFG_DATA_W-1:0] vals  [6];
        logic [CFG_ADDR_W-1:0] addrs [6];
        drain_results();
        addrs[0] = REG_KP;     vals[0] = kp;
        addrs[1] = REG_KI;     vals[1] = ki;
        addrs[2] = REG_KD;     vals[2] = kd;
        addrs[3] = REG_MODE;   vals[3] = CFG_DATA_W'(md);
        addrs[4] = REG_LIMIT;  vals[4] = CFG_DATA_W'(lim);
        addrs[5] = REG_PERIOD; vals[5] = CFG_DATA_W'(per);
        for (int i = 0; i < 6; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= addrs[i];
            cfg_data <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        kp_reg     = kp;
        ki_reg     = ki;
        kd_reg     = kd;
        mode_reg   = md;
        limit_reg  = lim;
        period_reg = per;
    endtask

    // output side: check accepted items, then decide next ready
    always @(posedge clk)
    begin
        drive_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (pending_drives.size() == 0)
                report_mismatch($sformatf("unexpected item drive=%0d computed=%0b",
                                          $signed(m_tdata[DATA_WIDTH-1:0]), m_tuser[0]));
            else
            begin
                want = pending_drives.pop_front();
                if (want.computed)
                    computed_seen++;
                if (m_tdata[DATA_WIDTH-1:0] !== want.drive)
                    report_mismatch($sformatf("drive got %0d want %0d",
                                              $signed(m_tdata[DATA_WIDTH-1:0]), want.drive));
                if (m_tuser[0] !== want.computed)
                    report_mismatch($sformatf("computed got %0b want %0b",
                                              m_tuser[0], want.computed));
            end
        end
        if (hold_seq != hold_seen)
        begin
            hold_seen    = hold_seq;
            rx_hold_left = hold_len;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            rx_stall_left = pick_gap(rx_idle_on);
            m_tready <= (rx_stall_left == 0);
            if (rx_stall_left > 0)
                rx_stall_left--;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // reset values: an early sample echoes, one after twenty ticks computes
    task automatic test_defaults();
        push_item(OP_SAMPLE, 0, 0, -32768);
        push_item(OP_SAMPLE, 0, 0, 32767);
        for (int i = 0; i < 20; i++)
            push_item(OP_TICK, DATA_WIDTH'($urandom), DATA_WIDTH'($urandom),
                      DATA_WIDTH'($urandom));
        push_item(OP_SAMPLE, 100, 300, 0);
    endtask

    // full scale gains and data, reserved mode, zero limit, zero period
    task automatic test_gain_extremes();
        set_config('1, '1, '1, MODE_PID, 15'd32767, '0);
        push_item(OP_SAMPLE, -32768, 32767, 0);
        push_item(OP_SAMPLE, 32767, -32768, 0);
        push_item(OP_SAMPLE, 0, 0, 0);
        set_config(24'd256, 24'd512, 24'd128, MODE_RESERVED, 15'd32767, '0);
        push_item(OP_SAMPLE, 10, 200, 0);
        push_item(OP_SAMPLE, 50, 20, 0);
        set_config('1, '1, '1, MODE_PID, '0, '0);
        push_item(OP_SAMPLE, -32768, 32767, 5);
    endtask

    // p only, then p plus d; the sum keeps moving in both
    task automatic test_modes();
        set_config(24'd256, 24'd1000, 24'd512, MODE_P, 15'd32767, '0);
        push_item(OP_SAMPLE, 0, 100, 0);
        push_item(OP_SAMPLE, 0, -40, 0);
        set_config(24'd256, 24'd1000, 24'd512, MODE_PD, 15'd32767, '0);
        push_item(OP_SAMPLE, 0, 100, 0);
        push_item(OP_SAMPLE, 0, 30, 0);
    endtask

    // negative fractions truncate toward zero
    task automatic test_rounding();
        set_config(24'd1, '0, '0, MODE_P, 15'd32767, '0);
        push_item(OP_SAMPLE, 255, 0, 0);
        push_item(OP_SAMPLE, 513, 0, 0);
        push_item(OP_SAMPLE, 0, 513, 0);
    endtask

    // sample before and after the period has run out
    task automatic test_period_gate();
        set_config(24'd256, '0, '0, MODE_PD, 15'd32767, 16'd3);
        push_item(OP_SAMPLE, 1, 2, 1234);
        repeat (3) push_item(OP_TICK, 0, 0, 0);
        push_item(OP_SAMPLE, 1, 9, 1234);
        push_item(OP_SAMPLE, 1, 9, -1234);
    endtask

    // swing the error sum far positive, then far negative, at full error
    task automatic test_sum_swing();
        set_config('0, 24'd1, '0, MODE_PID, 15'd32767, '0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (40) push_item(OP_SAMPLE, -32768, 32767, 0);
        repeat (80) push_item(OP_SAMPLE, 32767, -32768, 0);
        repeat (20) push_item(OP_SAMPLE, -32768, 32767, 0);
    endtask

    // long output stall while the input keeps offering
    task automatic test_backpressure();
        int stalls_before;
        set_config(24'd300, 24'd7, 24'd90, MODE_PID, 15'd20000, '0);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        stalls_before = in_stall_count;
        hold_len = 300;
        hold_seq++;
        for (int i = 0; i < 40; i++)
            push_item((i % 3 == 0) ? OP_TICK : OP_SAMPLE, DATA_WIDTH'($urandom),
                      DATA_WIDTH'($urandom), DATA_WIDTH'($urandom));
        if (in_stall_count == stalls_before)
            $display("note: input never stalled under the output hold");
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] rand_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return -32768;
        if (r < 16)
            return 32767;
        if (r < 20)
            return 0;
        if (r < 24)
            return -1;
        return DATA_WIDTH'($urandom);
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        if (r < 30)
            return '1;
        if (r < 75)
            return GAIN_W'($urandom_range(0, 1024));
        return GAIN_W'($urandom);
    endfunction

    function automatic logic [LIMIT_W-1:0] rand_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 25)
            return 15'd32767;
        return LIMIT_W'($urandom_range(1, 32767));
    endfunction

    function automatic logic [TICK_W-1:0] rand_period();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return TICK_W'($urandom_range(0, 3));
        if (r < 90)
            return TICK_W'($urandom_range(4, 12));
        return TICK_W'($urandom_range(13, 40));
    endfunction

    // random phases, each with its own register setting; mode cycles
    task automatic test_random(input int phases, input int per_phase);
        int tick_pct;
        for (int p = 0; p < phases; p++)
        begin
            set_config(rand_gain(), rand_gain(), rand_gain(), MODE_W'(p % 4),
                       rand_limit(), rand_period());
            // first phase runs without input gaps, second without output stalls
            tx_idle_on = (p != 0);
            rx_idle_on = (p != 1);
            tick_pct = (period_reg == 0) ? 30 : ((period_reg < 4) ? 55 : 80);
            for (int i = 0; i < per_phase; i++)
                push_item(($urandom_range(0, 99) < tick_pct) ? OP_TICK : OP_SAMPLE,
                          rand_data(), rand_data(), rand_data());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_defaults();
        test_gain_extremes();
        test_modes();
        test_rounding();
        test_period_gate();
        test_backpressure();
        test_sum_swing();
        test_random(5, 100);
        drain_results();

        $display("covered defaults, gain and data extremes, all four modes, truncation,");
        $display("period gate and wide sum swings: %0d items in, %0d out (%0d computed), %0d input stalls",
                 items_in, results_seen, computed_seen, in_stall_count);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
